>>> rtl/core/pdr_pkg.sv
`timescale 1ns / 1ps

package pdr_pkg;

  localparam int ADC_BITS = 10;

  localparam int DUTY_W   = 7;
  localparam int ERR_W    = ADC_BITS + 1;
  localparam int STAT_W   = 3;
  localparam int ITER_W   = 16;
  localparam int SAT_W    = 8;
  localparam int TOL_W    = 10;
  localparam int GAIN_W   = 16;
  localparam int MAXIT_W  = 16;
  localparam int CMP_W    = 17;
  localparam int PROD_W   = ADC_BITS + GAIN_W;
  localparam int DSUM_W   = ADC_BITS + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = ((DUTY_W + ADC_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((DUTY_W + ERR_W + ITER_W + 7) / 8) * 8;

  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);
  localparam logic [SAT_W-1:0]  SAT_TOP  = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SATLIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXITER = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_RUNNING   = 3'd0;
  localparam logic [STAT_W-1:0] ST_REACHED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_SATURATED = 3'd2;
  localparam logic [STAT_W-1:0] ST_LOST      = 3'd3;
  localparam logic [STAT_W-1:0] ST_LIMIT     = 3'd4;
  localparam logic [STAT_W-1:0] ST_IDLE      = 3'd5;

  localparam logic FUNC_START  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic [ADC_BITS-1:0] target_level;
    logic [TOL_W-1:0]    tolerance;
    logic [GAIN_W-1:0]   gain_q16;
    logic [SAT_W-1:0]    rail_limit;
    logic [MAXIT_W-1:0]  max_iterations;
  } cfg_t;

  typedef struct packed {
    logic                func;
    logic [DUTY_W-1:0]   initial_duty;
    logic [ADC_BITS-1:0] adc_sample;
    logic                sensor_lost;
  } item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty_out;
    logic signed [ERR_W-1:0] error_out;
    logic [STAT_W-1:0]       status;
    logic [ITER_W-1:0]       iteration;
  } res_t;

endpackage

>>> rtl/core/pdr_cfg_regs.sv
`timescale 1ns / 1ps

module pdr_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output pdr_pkg::cfg_t                     cfg
);

  pdr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_level     <= '0;
      cfg_r.tolerance        <= pdr_pkg::TOL_W'(5);
      cfg_r.gain_q16         <= pdr_pkg::GAIN_W'(3277);
      cfg_r.rail_limit       <= pdr_pkg::SAT_W'(5);
      cfg_r.max_iterations   <= pdr_pkg::MAXIT_W'(100);
    end else if (cfg_we) begin
      case (cfg_addr)
        pdr_pkg::CFG_TARGET:  cfg_r.target_level     <= cfg_wdata[pdr_pkg::ADC_BITS-1:0];
        pdr_pkg::CFG_TOL:     cfg_r.tolerance        <= cfg_wdata[pdr_pkg::TOL_W-1:0];
        pdr_pkg::CFG_GAIN:    cfg_r.gain_q16         <= cfg_wdata[pdr_pkg::GAIN_W-1:0];
        pdr_pkg::CFG_SATLIM:  cfg_r.rail_limit       <= cfg_wdata[pdr_pkg::SAT_W-1:0];
        pdr_pkg::CFG_MAXITER: cfg_r.max_iterations   <= cfg_wdata[pdr_pkg::MAXIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/pdr_step.sv
`timescale 1ns / 1ps

module pdr_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  pdr_pkg::item_t item,
  input  pdr_pkg::cfg_t  cfg,
  output pdr_pkg::res_t  res
);

  logic [pdr_pkg::DUTY_W-1:0]  duty_r, duty_nxt;
  logic [pdr_pkg::SAT_W-1:0]   sat_cnt_r, sat_cnt_nxt;
  logic [pdr_pkg::ITER_W-1:0]  smp_cnt_r, smp_cnt_nxt;
  logic                        active_r, active_nxt;

  logic signed [pdr_pkg::ERR_W-1:0]  err;
  logic [pdr_pkg::ADC_BITS-1:0]      mag;
  logic [pdr_pkg::ERR_W-1:0]         err_neg;
  logic                              err_pos;
  logic                              in_tol;
  logic                              at_rail;
  logic [pdr_pkg::SAT_W-1:0]         sat_inc;
  logic [pdr_pkg::PROD_W-1:0]        prod;
  logic [pdr_pkg::ADC_BITS-1:0]      step;
  logic [pdr_pkg::DSUM_W-1:0]        duty_ext;
  logic [pdr_pkg::DSUM_W-1:0]        step_ext;
  logic [pdr_pkg::DSUM_W-1:0]        duty_up;
  logic [pdr_pkg::DUTY_W-1:0]        duty_step;
  logic [pdr_pkg::ITER_W-1:0]        smp_inc;

  always_comb begin
    err      = $signed({1'b0, cfg.target_level}) - $signed({1'b0, item.adc_sample});
    err_neg  = -err;
    mag      = err[pdr_pkg::ERR_W-1] ? err_neg[pdr_pkg::ADC_BITS-1:0]
                                     : err[pdr_pkg::ADC_BITS-1:0];
    err_pos  = !err[pdr_pkg::ERR_W-1] && (err != '0);
    in_tol   = ({{(pdr_pkg::CMP_W-pdr_pkg::ADC_BITS){1'b0}}, mag}
                <= {{(pdr_pkg::CMP_W-pdr_pkg::TOL_W){1'b0}}, cfg.tolerance});
    at_rail  = (duty_r == '0) || (duty_r == pdr_pkg::DUTY_MAX);
    sat_inc  = (sat_cnt_r == pdr_pkg::SAT_TOP) ? sat_cnt_r : sat_cnt_r + 1'b1;

    // q16 gain, truncated, never below one step
    prod     = {{pdr_pkg::GAIN_W{1'b0}}, mag} * {{pdr_pkg::ADC_BITS{1'b0}}, cfg.gain_q16};
    step     = prod[pdr_pkg::PROD_W-1:pdr_pkg::GAIN_W];
    if (step == '0) begin
      step = pdr_pkg::ADC_BITS'(1);
    end
    duty_ext = {{(pdr_pkg::DSUM_W-pdr_pkg::DUTY_W){1'b0}}, duty_r};
    step_ext = {1'b0, step};
    duty_up  = duty_ext + step_ext;
    if (err_pos) begin
      duty_step = (step_ext >= duty_ext) ? '0 : duty_r - step[pdr_pkg::DUTY_W-1:0];
    end else begin
      duty_step = (duty_up > {{(pdr_pkg::DSUM_W-pdr_pkg::DUTY_W){1'b0}}, pdr_pkg::DUTY_MAX})
                  ? pdr_pkg::DUTY_MAX : duty_up[pdr_pkg::DUTY_W-1:0];
    end
    smp_inc  = smp_cnt_r + 1'b1;

    duty_nxt    = duty_r;
    sat_cnt_nxt = sat_cnt_r;
    smp_cnt_nxt = smp_cnt_r;
    active_nxt  = active_r;
    res.error_out = '0;
    res.status    = pdr_pkg::ST_RUNNING;

    if (item.func == pdr_pkg::FUNC_START) begin
      duty_nxt    = (item.initial_duty > pdr_pkg::DUTY_MAX) ? pdr_pkg::DUTY_MAX
                                                            : item.initial_duty;
      sat_cnt_nxt = '0;
      smp_cnt_nxt = '0;
      active_nxt  = 1'b1;
    end else if (!active_r) begin
      res.status = pdr_pkg::ST_IDLE;
    end else if (item.sensor_lost) begin
      active_nxt = 1'b0;
      res.status = pdr_pkg::ST_LOST;
    end else begin
      smp_cnt_nxt   = smp_inc;
      res.error_out = err;
      if (in_tol) begin
        active_nxt = 1'b0;
        res.status = pdr_pkg::ST_REACHED;
      end else if (at_rail && (sat_inc >= cfg.rail_limit)) begin
        sat_cnt_nxt = sat_inc;
        active_nxt  = 1'b0;
        res.status  = pdr_pkg::ST_SATURATED;
      end else begin
        sat_cnt_nxt = at_rail ? sat_inc : '0;
        duty_nxt    = duty_step;
        if (smp_inc >= cfg.max_iterations) begin
          active_nxt = 1'b0;
          res.status = pdr_pkg::ST_LIMIT;
        end
      end
    end

    res.duty_out  = duty_nxt;
    res.iteration = smp_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r    <= '0;
      sat_cnt_r <= '0;
      smp_cnt_r <= '0;
      active_r  <= 1'b0;
    end else if (fire) begin
      duty_r    <= duty_nxt;
      sat_cnt_r <= sat_cnt_nxt;
      smp_cnt_r <= smp_cnt_nxt;
      active_r  <= active_nxt;
    end
  end

endmodule

>>> rtl/core/proportional_duty_regulator_top.sv
`timescale 1ns / 1ps
// an input beat passes the input register and then the result register to become its result beat
// throughput: one item per cycle while the output is not stalled; the duty and counters update
// in the same cycle as the step logic, so the next item sees them at once, bounded by the 10x16
// gain multiply and clamp; reset: synchronous active-low rst_n empties both registers, clears
// duty and counters, leaves the loop idle and loads the default configuration

module proportional_duty_regulator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pdr_pkg::IN_DATA_W-1:0]      in_tdata,   // initial_duty, adc_sample, sensor_lost
  input  logic                               in_tuser,   // func
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pdr_pkg::OUT_DATA_W-1:0]     out_tdata,  // duty_out, error_out, iteration
  output logic [pdr_pkg::STAT_W-1:0]         out_tuser,  // status
  input  logic                               cfg_we,
  input  logic [pdr_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [pdr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int SMP_LO  = pdr_pkg::DUTY_W;
  localparam int LOST_B  = pdr_pkg::DUTY_W + pdr_pkg::ADC_BITS;
  localparam int OUT_USED = pdr_pkg::DUTY_W + pdr_pkg::ERR_W + pdr_pkg::ITER_W;

  pdr_pkg::cfg_t  cfg;
  pdr_pkg::item_t item_r;
  pdr_pkg::res_t  res;
  pdr_pkg::res_t  res_r;
  logic           in_vld_r;
  logic           out_vld_r;
  logic           advance;
  logic           fire;

  assign advance   = !out_vld_r || out_tready;
  assign fire      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.func         <= in_tuser;
      item_r.initial_duty <= in_tdata[pdr_pkg::DUTY_W-1:0];
      item_r.adc_sample   <= in_tdata[LOST_B-1:SMP_LO];
      item_r.sensor_lost  <= in_tdata[LOST_B];
    end
  end

  pdr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdr_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(pdr_pkg::OUT_DATA_W-OUT_USED){1'b0}},
                       res_r.iteration, res_r.error_out, res_r.duty_out};
  assign out_tuser  = res_r.status;

endmodule

>>> rtl/core/pdr_checker.sv
`timescale 1ns / 1ps

module pdr_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [pdr_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic [pdr_pkg::STAT_W-1:0]         out_tuser
);

  localparam int ERR_LO = pdr_pkg::DUTY_W;
  localparam int ERR_HI = pdr_pkg::DUTY_W + pdr_pkg::ERR_W - 1;

  // duty is always clamped into the percent range
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[pdr_pkg::DUTY_W-1:0] <= pdr_pkg::DUTY_MAX))
    else $error("duty above 100");

  // no error is reported when the sample was not used
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == pdr_pkg::ST_IDLE || out_tuser == pdr_pkg::ST_LOST)
    |-> (out_tdata[ERR_HI:ERR_LO] == '0))
    else $error("nonzero error on idle or lost result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind proportional_duty_regulator_top pdr_checker u_pdr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/proportional_duty_regulator_top_test.sv
`timescale 1ns / 1ps

module proportional_duty_regulator_top_test;

  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [pdr_pkg::IN_DATA_W-1:0] in_tdata = '0;    // initial_duty, adc_sample, sensor_lost
  logic in_tuser = 1'b0;                           // func
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [pdr_pkg::OUT_DATA_W-1:0] out_tdata;       // duty_out, error_out, iteration
  logic [pdr_pkg::STAT_W-1:0] out_tuser;           // status
  logic cfg_we = 1'b0;
  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [pdr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  proportional_duty_regulator_top u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // loop state as the block should hold it
  pdr_pkg::cfg_t loop_cfg;
  logic [pdr_pkg::DUTY_W-1:0] loop_duty;
  logic [pdr_pkg::SAT_W-1:0] pinned_count;
  logic [pdr_pkg::ITER_W-1:0] run_samples;
  logic run_open;

  pdr_pkg::res_t duty_forecast[$];
  int mismatches = 0;
  int results_seen = 0;
  int taken_items = 0;
  logic gaps_on = 1'b1;
  logic stalls_on = 1'b1;
  logic hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("proportional_duty_regulator_top_test failed");
    $finish;
  end

  function automatic pdr_pkg::res_t regulate(input pdr_pkg::item_t it);
    pdr_pkg::res_t r;
    int err;
    int mag;
    int nd;
    logic pinned;
    r = '0;
    if (it.func == pdr_pkg::FUNC_START) begin
      loop_duty = (it.initial_duty > pdr_pkg::DUTY_MAX) ? pdr_pkg::DUTY_MAX : it.initial_duty;
      pinned_count = '0;
      run_samples = '0;
      run_open = 1'b1;
      r.status = pdr_pkg::ST_RUNNING;
    end else if (!run_open) begin
      r.status = pdr_pkg::ST_IDLE;
    end else if (it.sensor_lost) begin
      run_open = 1'b0;
      r.status = pdr_pkg::ST_LOST;
    end else begin
      err = int'(loop_cfg.target_level) - int'(it.adc_sample);
      run_samples = run_samples + 1'b1;
      mag = (err < 0) ? -err : err;
      r.error_out = pdr_pkg::ERR_W'(err);
      pinned = (loop_duty == '0) || (loop_duty == pdr_pkg::DUTY_MAX);
      if (pinned) begin
        if (pinned_count != pdr_pkg::SAT_TOP) pinned_count = pinned_count + 1'b1;
      end else begin
        pinned_count = '0;
      end
      // deadband wins over the saturation check
      if (mag <= int'(loop_cfg.tolerance)) begin
        run_open = 1'b0;
        r.status = pdr_pkg::ST_REACHED;
      end else if (pinned && pinned_count >= loop_cfg.rail_limit) begin
        run_open = 1'b0;
        r.status = pdr_pkg::ST_SATURATED;
      end else begin
        mag = int'((longint'(mag) * longint'(loop_cfg.gain_q16)) >>> 16);
        if (mag < 1) mag = 1;
        nd = int'(loop_duty) + ((err > 0) ? -mag : mag);
        if (nd < 0) nd = 0;
        if (nd > 100) nd = 100;
        loop_duty = pdr_pkg::DUTY_W'(nd);
        if (run_samples >= loop_cfg.max_iterations) begin
          run_open = 1'b0;
          r.status = pdr_pkg::ST_LIMIT;
        end else begin
          r.status = pdr_pkg::ST_RUNNING;
        end
      end
    end
    r.duty_out = loop_duty;
    r.iteration = run_samples;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // result check first, then the forecast for the beat taken in at this edge
  always @(posedge clk) begin
    pdr_pkg::res_t want;
    pdr_pkg::item_t it;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (duty_forecast.size() == 0) begin
          report_mismatch("unexpected beat, status", longint'(out_tuser), longint'(-1));
        end else begin
          want = duty_forecast.pop_front();
          if (out_tdata[pdr_pkg::DUTY_W-1:0] !== want.duty_out)
            report_mismatch("duty_out", longint'(out_tdata[pdr_pkg::DUTY_W-1:0]),
                            longint'(want.duty_out));
          if ($signed(out_tdata[pdr_pkg::DUTY_W +: pdr_pkg::ERR_W]) !== want.error_out)
            report_mismatch("error_out",
                            longint'($signed(out_tdata[pdr_pkg::DUTY_W +: pdr_pkg::ERR_W])),
                            longint'(want.error_out));
          if (out_tuser !== want.status)
            report_mismatch("status", longint'(out_tuser), longint'(want.status));
          if (out_tdata[pdr_pkg::DUTY_W+pdr_pkg::ERR_W +: pdr_pkg::ITER_W] !== want.iteration)
            report_mismatch("iteration",
                            longint'(out_tdata[pdr_pkg::DUTY_W+pdr_pkg::ERR_W +: pdr_pkg::ITER_W]),
                            longint'(want.iteration));
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        it.func = in_tuser;
        it.initial_duty = in_tdata[pdr_pkg::DUTY_W-1:0];
        it.adc_sample = in_tdata[pdr_pkg::DUTY_W +: pdr_pkg::ADC_BITS];
        it.sensor_lost = in_tdata[pdr_pkg::DUTY_W+pdr_pkg::ADC_BITS];
        want = regulate(it);
        taken_items++;
        duty_forecast.push_back(want);
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        for (n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic func, input logic [pdr_pkg::DUTY_W-1:0] init,
                           input logic [pdr_pkg::ADC_BITS-1:0] sample, input logic lost);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= pdr_pkg::IN_DATA_W'({lost, sample, init});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_sample(input int level, input logic lost);
    if (level < 0) level = 0;
    if (level > 1023) level = 1023;
    send_item(pdr_pkg::FUNC_SAMPLE, pdr_pkg::DUTY_W'($urandom),
              pdr_pkg::ADC_BITS'(level), lost);
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (duty_forecast.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pdr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pdr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_settings(input int target, input int tol, input int gain,
                               input int satlim, input int maxit);
    settle();
    write_reg(pdr_pkg::CFG_TARGET, pdr_pkg::CFG_DATA_W'(target));
    write_reg(pdr_pkg::CFG_TOL, pdr_pkg::CFG_DATA_W'(tol));
    write_reg(pdr_pkg::CFG_GAIN, pdr_pkg::CFG_DATA_W'(gain));
    write_reg(pdr_pkg::CFG_SATLIM, pdr_pkg::CFG_DATA_W'(satlim));
    write_reg(pdr_pkg::CFG_MAXITER, pdr_pkg::CFG_DATA_W'(maxit));
    @(negedge clk);
    cfg_we <= 1'b0;
    loop_cfg.target_level = pdr_pkg::ADC_BITS'(target);
    loop_cfg.tolerance = pdr_pkg::TOL_W'(tol);
    loop_cfg.gain_q16 = pdr_pkg::GAIN_W'(gain);
    loop_cfg.rail_limit = pdr_pkg::SAT_W'(satlim);
    loop_cfg.max_iterations = pdr_pkg::MAXIT_W'(maxit);
  endtask

  task automatic load_random_settings();
    int target, tol, gain, satlim, maxit;
    case ($urandom_range(0, 7))
      0: target = 0;
      1: target = 1023;
      default: target = $urandom_range(100, 923);
    endcase
    case ($urandom_range(0, 11))
      0: tol = 0;
      1: tol = 1023;
      default: tol = $urandom_range(1, 20);
    endcase
    case ($urandom_range(0, 7))
      0: gain = 0;
      1: gain = 65535;
      default: gain = $urandom_range(1000, 30000);
    endcase
    case ($urandom_range(0, 9))
      0: satlim = 0;
      1: satlim = 255;
      default: satlim = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 11))
      0: maxit = 0;
      1: maxit = 1;
      2: maxit = 65535;
      default: maxit = $urandom_range(2, 60);
    endcase
    load_settings(target, tol, gain, satlim, maxit);
  endtask

  // runs against a crude plant: reading rises as the duty falls below its balance point
  task automatic regulate_runs(input int goal);
    int stop, len, balance, slope, k, tol, level;
    stop = taken_items + goal;
    while (taken_items < stop) begin
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 7) == 0)
          send_item(pdr_pkg::FUNC_START, pdr_pkg::DUTY_W'($urandom_range(101, 127)),
                    pdr_pkg::ADC_BITS'($urandom), 1'($urandom));
        else
          send_item(pdr_pkg::FUNC_START, pdr_pkg::DUTY_W'($urandom_range(0, 100)),
                    pdr_pkg::ADC_BITS'($urandom), 1'($urandom));
      end
      balance = int'($urandom_range(0, 160)) - 30;
      slope = $urandom_range(1, 8);
      tol = int'(loop_cfg.tolerance);
      len = $urandom_range(1, 40);
      repeat (len) begin
        k = $urandom_range(0, 19);
        if (k == 0) begin
          send_sample($urandom_range(0, 1023), 1'b1);
        end else if (k < 3) begin
          send_sample($urandom_range(0, 1023), 1'b0);
        end else if (k < 6) begin
          level = int'(loop_cfg.target_level) + int'($urandom_range(0, 2 * tol + 4)) - tol - 2;
          send_sample(level, 1'b0);
        end else begin
          level = int'(loop_cfg.target_level) + (balance - int'(loop_duty)) * slope
                  + int'($urandom_range(0, 6)) - 3;
          send_sample(level, 1'b0);
        end
      end
    end
  endtask

  task automatic test_start_and_idle();
    send_sample(700, 1'b0);            // no run yet
    send_item(pdr_pkg::FUNC_START, 7'd127, 10'h3ff, 1'b1);
    send_item(pdr_pkg::FUNC_START, 7'd0, 10'h000, 1'b0);
    send_item(pdr_pkg::FUNC_START, 7'd100, 10'h155, 1'b0);
    send_item(pdr_pkg::FUNC_START, 7'd50, 10'h2aa, 1'b1);
  endtask

  task automatic test_reach_and_step();
    send_sample(1023, 1'b0);           // big step, clamped at the top
    send_sample(4, 1'b0);              // inside the deadband
    send_sample(700, 1'b0);            // run is over
  endtask

  task automatic test_sensor_lost();
    send_item(pdr_pkg::FUNC_START, 7'd30, 10'd0, 1'b0);
    send_sample(1023, 1'b1);
    send_sample(300, 1'b0);
  endtask

  task automatic test_saturation();
    send_item(pdr_pkg::FUNC_START, 7'd100, 10'd0, 1'b0);
    repeat (5) send_sample(600, 1'b0);
  endtask

  task automatic test_register_extremes();
    load_settings(1023, 0, 0, 0, 65535);
    send_item(pdr_pkg::FUNC_START, 7'd50, 10'd0, 1'b0);
    send_sample(1000, 1'b0);           // zero gain still steps by one
    send_sample(1023, 1'b0);
    send_item(pdr_pkg::FUNC_START, 7'd0, 10'd0, 1'b0);
    send_sample(0, 1'b0);              // zero limit ends on the first pinned sample
    load_settings(512, 1023, 65535, 1, 0);
    send_item(pdr_pkg::FUNC_START, 7'd60, 10'd0, 1'b0);
    send_sample(0, 1'b0);
    load_settings(512, 0, 65535, 255, 0);
    send_item(pdr_pkg::FUNC_START, 7'd60, 10'd0, 1'b0);
    send_sample(0, 1'b0);
    load_settings(0, 0, 65535, 5, 1);
    send_item(pdr_pkg::FUNC_START, 7'd10, 10'd0, 1'b0);
    send_sample(1023, 1'b0);
  endtask

  task automatic test_backpressure();
    load_settings(600, 3, 6000, 8, 50);
    hold_req = 1'b1;
    send_item(pdr_pkg::FUNC_START, 7'd40, 10'd0, 1'b0);
    repeat (40) send_sample($urandom_range(0, 1023), 1'b0);
  endtask

  task automatic test_pinned_ceiling();
    load_settings(1023, 0, 3277, 255, 65535);
    send_item(pdr_pkg::FUNC_START, 7'd0, 10'd0, 1'b0);
    repeat (256) send_sample($urandom_range(0, 1000), 1'b0);
  endtask

  task automatic test_random_regulation();
    repeat (5) begin
      load_random_settings();
      regulate_runs(140);
    end
  endtask

  task automatic test_steady_flow();
    settle();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    load_random_settings();
    regulate_runs(150);
  endtask

  initial begin
    loop_cfg.target_level = '0;
    loop_cfg.tolerance = pdr_pkg::TOL_W'(5);
    loop_cfg.gain_q16 = pdr_pkg::GAIN_W'(3277);
    loop_cfg.rail_limit = pdr_pkg::SAT_W'(5);
    loop_cfg.max_iterations = pdr_pkg::MAXIT_W'(100);
    loop_duty = '0;
    pinned_count = '0;
    run_samples = '0;
    run_open = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_start_and_idle();
    test_reach_and_step();
    test_sensor_lost();
    test_saturation();
    test_register_extremes();
    test_backpressure();
    test_pinned_ceiling();
    test_random_regulation();
    test_steady_flow();
    settle();

    if (mismatches == 0 && duty_forecast.size() == 0) begin
      $display("proportional_duty_regulator_top_test passed");
    end else begin
      $display("proportional_duty_regulator_top_test failed");
    end
    $finish;
  end

endmodule
